// ===== hdl/dcrb_pkg.sv =====
`default_nettype none

package dcrb_pkg;

  localparam int BufDepth = 32;
  localparam int AddrW    = $clog2(BufDepth);
  localparam logic [7:0] CksumSeed = 8'h50;

  typedef enum logic [3:0] {
    ActAddrMatch = 4'd0,
    ActTxReq     = 4'd1,
    ActRxByte    = 4'd2,
    ActNak       = 4'd3,
    ActLost      = 4'd4,
    ActLoadTx    = 4'd5,
    ActSetCount  = 4'd6,
    ActReadRx    = 4'd7,
    ActClearCmd  = 4'd8
  } action_e;

  typedef struct packed {
    logic [3:0] action;
    logic       channel;
    logic       is_read;
    logic [7:0] data;
    logic [4:0] index;
    logic [4:0] count;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       end_of_reply;
    logic       enable_tx;
    logic       ack_req;
    logic [7:0] rx_data;
    logic [4:0] rx_fill;
    logic       cmd_pending;
    logic       active_channel;
  } out_item_t;

  typedef struct packed {
    logic             tx_we;
    logic [AddrW-1:0] tx_addr;
    logic [7:0]       tx_data;
    logic             rx_we;
    logic [AddrW-1:0] rx_addr;
    logic [7:0]       rx_data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ===== hdl/dcrb_store.sv =====
`default_nettype none

module dcrb_store (
  input  wire logic                      clk_i,
  input  wire logic                      rd_en_i,
  input  wire logic [dcrb_pkg::AddrW-1:0] tx_rd_addr_i,
  input  wire logic [dcrb_pkg::AddrW-1:0] rx_rd_addr_i,
  input  wire dcrb_pkg::mem_wr_t         wr_i,
  output logic [7:0]                     tx_rd_data_o,
  output logic [7:0]                     rx_rd_data_o
);
  import dcrb_pkg::*;

  logic [7:0] tx_mem [BufDepth];
  logic [7:0] rx_mem [BufDepth];
  logic [7:0] tx_rd_q;
  logic [7:0] rx_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.tx_we) begin
      tx_mem[wr_i.tx_addr] <= wr_i.tx_data;
    end
    if (wr_i.rx_we) begin
      rx_mem[wr_i.rx_addr] <= wr_i.rx_data;
    end
  end

  // write-through so a beat right behind a write sees the new byte
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.tx_we && (wr_i.tx_addr == tx_rd_addr_i)) begin
        tx_rd_q <= wr_i.tx_data;
      end else begin
        tx_rd_q <= tx_mem[tx_rd_addr_i];
      end
      if (wr_i.rx_we && (wr_i.rx_addr == rx_rd_addr_i)) begin
        rx_rd_q <= wr_i.rx_data;
      end else begin
        rx_rd_q <= rx_mem[rx_rd_addr_i];
      end
    end
  end

  assign tx_rd_data_o = tx_rd_q;
  assign rx_rd_data_o = rx_rd_q;

endmodule

`default_nettype wire

// ===== hdl/dcrb_engine.sv =====
`default_nettype none

module dcrb_engine (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire dcrb_pkg::in_item_t         item_i,
  input  wire logic                       factory_mode_i,
  input  wire logic [7:0]                 tx_rd_data_i,
  input  wire logic [7:0]                 rx_rd_data_i,
  output logic [dcrb_pkg::AddrW-1:0]      tx_rd_addr_o,
  output dcrb_pkg::mem_wr_t               wr_o,
  output logic                            strobe_o,
  output dcrb_pkg::out_item_t             result_o
);
  import dcrb_pkg::*;

  in_item_t         in_q;
  logic             vld_q;
  logic [AddrW-1:0] tx_pos_q, tx_pos_d;
  logic [AddrW-1:0] tx_len_q, tx_len_d;
  logic [AddrW-1:0] rx_pos_q, rx_pos_d;
  logic [7:0]       xor_q, xor_d;
  logic             cmd_q, cmd_d;
  logic             port_q, port_d;
  out_item_t        res_q, res_d;
  logic             strobe_q;
  logic             idx_ok;

  assign idx_ok = int'(in_q.index) < BufDepth;

  always_comb begin
    tx_pos_d = tx_pos_q;
    tx_len_d = tx_len_q;
    rx_pos_d = rx_pos_q;
    xor_d    = xor_q;
    cmd_d    = cmd_q;
    port_d   = port_q;
    res_d    = '0;
    wr_o     = '0;
    wr_o.tx_addr = AddrW'(in_q.index);
    wr_o.tx_data = in_q.data;
    wr_o.rx_addr = rx_pos_q;
    wr_o.rx_data = in_q.data;
    if (vld_q) begin
      if (in_q.action inside {[ActAddrMatch:ActLost]}) begin
        port_d = in_q.channel;
      end
      case (in_q.action)
        ActAddrMatch: begin
          if (in_q.is_read) begin
            res_d.enable_tx = 1'b1;
            tx_pos_d        = '0;
            xor_d           = CksumSeed;
          end else begin
            res_d.ack_req = 1'b1;
            rx_pos_d      = '0;
            cmd_d         = 1'b1;
          end
        end
        ActTxReq: begin
          res_d.tx_valid = 1'b1;
          if (tx_pos_q != tx_len_q) begin
            res_d.tx_byte = tx_rd_data_i;
            tx_pos_d = (tx_pos_q == AddrW'(BufDepth - 1)) ? '0 : tx_pos_q + AddrW'(1);
            if (!factory_mode_i) begin
              xor_d = xor_q ^ tx_rd_data_i;
            end
          end else begin
            res_d.tx_byte      = factory_mode_i ? tx_rd_data_i : xor_q;
            res_d.end_of_reply = 1'b1;
            tx_pos_d           = '0;
          end
        end
        ActRxByte: begin
          wr_o.rx_we = 1'b1;
          rx_pos_d = (rx_pos_q == AddrW'(BufDepth - 1)) ? AddrW'(2) : rx_pos_q + AddrW'(1);
        end
        ActLoadTx: begin
          wr_o.tx_we = idx_ok;
        end
        ActSetCount: begin
          tx_len_d = (int'(in_q.count) > BufDepth - 1) ? AddrW'(BufDepth - 1)
                                                       : AddrW'(in_q.count);
        end
        ActReadRx: begin
          if (idx_ok) begin
            res_d.rx_data = rx_rd_data_i;
          end
        end
        ActClearCmd: begin
          cmd_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
    res_d.rx_fill        = 5'(rx_pos_d);
    res_d.cmd_pending    = cmd_d;
    res_d.active_channel = port_d;
  end

  // the next item reads the transmit slot the current one leaves behind
  assign tx_rd_addr_o = tx_pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      strobe_q <= 1'b0;
      tx_pos_q <= '0;
      tx_len_q <= '0;
      rx_pos_q <= '0;
      xor_q    <= CksumSeed;
      cmd_q    <= 1'b0;
      port_q   <= 1'b0;
    end else begin
      vld_q    <= accept_i;
      strobe_q <= vld_q;
      tx_pos_q <= tx_pos_d;
      tx_len_q <= tx_len_d;
      rx_pos_q <= rx_pos_d;
      xor_q    <= xor_d;
      cmd_q    <= cmd_d;
      port_q   <= port_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      in_q <= item_i;
    end
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== hdl/ddc_ci_slave_reply_buffer.sv =====
`default_nettype none

// DDC/CI reply and command buffer for a two-port I2C slave. Each beat on
// item_i (start_i high while busy_o is low) is one bus event or one firmware
// access; busy_o never rises, so a beat may be issued every clock. Its result
// appears on result_o with strobe_o high for exactly one cycle, in order, and
// must be taken then: there is no back-pressure. Each result passes through
// the registered read of the 32-byte transmit and receive buffers and then the
// result register. factory_mode is to be written through cfg_we_i/cfg_wdata_i
// only while no beat is in flight; the block itself does not enforce this.
// Buffer slots read before they were ever loaded return unspecified data.
module ddc_ci_slave_reply_buffer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire dcrb_pkg::in_item_t   item_i,
  output logic                      strobe_o,
  output dcrb_pkg::out_item_t       result_o,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i
);
  import dcrb_pkg::*;

  logic             accept;
  logic             factory_q;
  logic [AddrW-1:0] tx_rd_addr;
  logic [7:0]       tx_rd_data;
  logic [7:0]       rx_rd_data;
  mem_wr_t          wr;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factory_q <= 1'b0;
    end else if (cfg_we_i) begin
      factory_q <= cfg_wdata_i;
    end
  end

  dcrb_store u_store (
    .clk_i        (clk_i),
    .rd_en_i      (accept),
    .tx_rd_addr_i (tx_rd_addr),
    .rx_rd_addr_i (AddrW'(item_i.index)),
    .wr_i         (wr),
    .tx_rd_data_o (tx_rd_data),
    .rx_rd_data_o (rx_rd_data)
  );

  dcrb_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (item_i),
    .factory_mode_i (factory_q),
    .tx_rd_data_i   (tx_rd_data),
    .rx_rd_data_i   (rx_rd_data),
    .tx_rd_addr_o   (tx_rd_addr),
    .wr_o           (wr),
    .strobe_o       (strobe_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

// ===== hdl/dcrb_checker.sv =====
`default_nettype none

module dcrb_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_i,
  input wire logic                strobe_i,
  input wire dcrb_pkg::out_item_t result_i
);

  // every beat is followed by its result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |-> ##2 strobe_i)
    else $error("beat without result");

  // no result without a beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_i |-> $past(start_i && !busy_i, 2))
    else $error("result without beat");

  a_eor_is_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_i && result_i.end_of_reply) |-> result_i.tx_valid)
    else $error("end of reply on a non-transmit result");

  a_ack_sets_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_i && result_i.ack_req) |-> (result_i.cmd_pending && !result_i.enable_tx
                                        && !result_i.tx_valid && result_i.rx_fill == 5'd0))
    else $error("write address match result inconsistent");

endmodule

bind ddc_ci_slave_reply_buffer dcrb_checker u_dcrb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_i   (busy_o),
  .strobe_i (strobe_o),
  .result_i (result_o)
);

`default_nettype wire
